FILE: rtl/spbc_pkg.sv
package spbc_pkg;

    localparam int ROUNDS_DEFAULT = 4;
    localparam int BLOCK_W        = 64;
    localparam int KEY_HIGH_W     = 16;

    typedef enum logic [1:0] {
        OP_ECB_ENC = 2'd0,
        OP_ECB_DEC = 2'd1,
        OP_CBC_ENC = 2'd2,
        OP_CBC_DEC = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_KEY_LOW     = 2'd0,
        CFG_KEY_HIGH    = 2'd1,
        CFG_INIT_VECTOR = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [BLOCK_W-1:0] data_out;
        logic               chain_we;
        logic [BLOCK_W-1:0] chain_next;
    } res_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,
        8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,
        8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,
        8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,
        8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,
        8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,
        8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,
        8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,
        8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,
        8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,
        8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,
        8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,
        8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,
        8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,
        8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,
        8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,
        8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [5:0] PBOX [64] = '{
        6'h08,6'h11,6'h1A,6'h23,6'h2C,6'h35,6'h3E,6'h09,
        6'h10,6'h19,6'h22,6'h2B,6'h34,6'h3D,6'h00,6'h12,
        6'h1B,6'h24,6'h2D,6'h36,6'h3F,6'h01,6'h0A,6'h1D,
        6'h21,6'h2E,6'h37,6'h3C,6'h02,6'h0B,6'h13,6'h20,
        6'h28,6'h33,6'h38,6'h03,6'h0C,6'h14,6'h18,6'h30,
        6'h31,6'h39,6'h04,6'h0D,6'h15,6'h1F,6'h26,6'h29,
        6'h3A,6'h05,6'h0E,6'h16,6'h1C,6'h3B,6'h06,6'h0F,
        6'h07,6'h17,6'h1E,6'h25,6'h27,6'h2A,6'h2F,6'h32
    };

    // inverse S-box is worked out at elaboration from the forward table
    function automatic logic [255:0][7:0] build_inv_sbox();
        logic [255:0][7:0] t;
        t = '0;
        for (int i = 0; i < 256; i++) begin
            t[SBOX[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam logic [255:0][7:0] INV_SBOX = build_inv_sbox();

    function automatic logic [BLOCK_W-1:0] sub_bytes(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        for (int i = 0; i < 8; i++) begin
            y[8*i +: 8] = SBOX[x[8*i +: 8]];
        end
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] inv_sub_bytes(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        for (int i = 0; i < 8; i++) begin
            y[8*i +: 8] = INV_SBOX[x[8*i +: 8]];
        end
        return y;
    endfunction

    // bit i moves to bit PBOX[i]
    function automatic logic [BLOCK_W-1:0] perm(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        for (int i = 0; i < BLOCK_W; i++) begin
            y[PBOX[i]] = x[i];
        end
        return y;
    endfunction

    // bit PBOX[i] moves back to bit i
    function automatic logic [BLOCK_W-1:0] inv_perm(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        for (int i = 0; i < BLOCK_W; i++) begin
            y[i] = x[PBOX[i]];
        end
        return y;
    endfunction

endpackage

FILE: rtl/spbc_key_sched.sv
module spbc_key_sched #(
    parameter int ROUNDS = spbc_pkg::ROUNDS_DEFAULT
) (
    input  logic [spbc_pkg::BLOCK_W-1:0]             key_low,
    input  logic [spbc_pkg::KEY_HIGH_W-1:0]          key_high,
    output logic [ROUNDS:0][spbc_pkg::BLOCK_W-1:0]   round_keys
);
    import spbc_pkg::*;

    localparam int EXTRA_W = 4 * ROUNDS;
    localparam int KEY_W   = BLOCK_W + EXTRA_W;

    logic [EXTRA_W-1:0] key_extra;
    logic [KEY_W-1:0]   key_full;

    // drop key_high bits beyond the key, pad missing upper bits with zero
    always_comb begin
        for (int b = 0; b < EXTRA_W; b++) begin
            key_extra[b] = (b < KEY_HIGH_W) ? key_high[b % KEY_HIGH_W] : 1'b0;
        end
    end

    assign key_full = {key_extra, key_low};

    for (genvar r = 0; r <= ROUNDS; r++) begin : g_rk
        assign round_keys[r] = key_full[4*(ROUNDS-r) +: BLOCK_W];
    end

endmodule

FILE: rtl/spbc_cipher.sv
module spbc_cipher #(
    parameter int ROUNDS = spbc_pkg::ROUNDS_DEFAULT
) (
    input  spbc_pkg::op_t                            op,
    input  logic                                     restart,
    input  logic [spbc_pkg::BLOCK_W-1:0]             data_in,
    input  logic [spbc_pkg::BLOCK_W-1:0]             init_vector,
    input  logic [spbc_pkg::BLOCK_W-1:0]             chain_value,
    input  logic [ROUNDS:0][spbc_pkg::BLOCK_W-1:0]   round_keys,
    output spbc_pkg::res_t                           res
);
    import spbc_pkg::*;

    logic [BLOCK_W-1:0] vec;
    logic [BLOCK_W-1:0] enc_in;
    logic [BLOCK_W-1:0] enc_out;
    logic [BLOCK_W-1:0] dec_out;
    logic [ROUNDS-1:0][BLOCK_W-1:0] enc_st;
    logic [ROUNDS-1:0][BLOCK_W-1:0] dec_st;

    assign vec    = restart ? init_vector : chain_value;
    assign enc_in = (op == OP_CBC_ENC) ? (data_in ^ vec) : data_in;

    // encrypt: full rounds, then key, substitute, key
    assign enc_st[0] = enc_in;
    for (genvar r = 0; r < ROUNDS - 1; r++) begin : g_enc
        assign enc_st[r+1] = perm(sub_bytes(enc_st[r] ^ round_keys[r]));
    end
    assign enc_out = sub_bytes(enc_st[ROUNDS-1] ^ round_keys[ROUNDS-1]) ^ round_keys[ROUNDS];

    // decrypt: undo the above, last round key first
    assign dec_st[0] = inv_sub_bytes(data_in ^ round_keys[ROUNDS]);
    for (genvar k = 1; k < ROUNDS; k++) begin : g_dec
        assign dec_st[k] = inv_sub_bytes(inv_perm(dec_st[k-1] ^ round_keys[ROUNDS-k]));
    end
    assign dec_out = dec_st[ROUNDS-1] ^ round_keys[0];

    always_comb begin
        res.data_out   = enc_out;
        res.chain_we   = 1'b0;
        res.chain_next = enc_out;
        unique case (op)
            OP_ECB_ENC: begin
                res.data_out = enc_out;
            end
            OP_ECB_DEC: begin
                res.data_out = dec_out;
            end
            OP_CBC_ENC: begin
                res.data_out   = enc_out;
                res.chain_we   = 1'b1;
                res.chain_next = enc_out;
            end
            OP_CBC_DEC: begin
                res.data_out   = dec_out ^ vec;
                res.chain_we   = 1'b1;
                res.chain_next = data_in;
            end
        endcase
    end

endmodule

FILE: rtl/spn_block_cipher_64.sv
// Channel  Dir  Handshake              Payload
// s_       in   s_tvalid / s_tready    s_tdata: data_in; s_tuser: operation, restart_chain
// m_       out  m_tvalid / m_tready    m_tdata: data_out
// cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word a cycle unless m_ stalls; words on s_ reach m_ through the input and result registers.
// The whole cipher (all ROUNDS rounds, unrolled) sits between the input and result register.
// CBC chaining updates as a word moves into the result register, so back-to-back CBC words chain.
// aresetn (synchronous) clears both stages, the chain value and the configuration registers.
// With m_tready low the result register holds, then the input register; s_tready drops then.
module spn_block_cipher_64 #(
    parameter int ROUNDS = spbc_pkg::ROUNDS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [spbc_pkg::BLOCK_W-1:0]    s_tdata,   // [63:0] data_in
    input  logic [2:0]                      s_tuser,   // [1:0] operation, [2] restart_chain
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [spbc_pkg::BLOCK_W-1:0]    m_tdata,   // [63:0] data_out
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [spbc_pkg::BLOCK_W-1:0]    cfg_data
);
    import spbc_pkg::*;

    logic [BLOCK_W-1:0]    key_low_reg;
    logic [KEY_HIGH_W-1:0] key_high_reg;
    logic [BLOCK_W-1:0]    iv_reg;
    logic [BLOCK_W-1:0]    chain_reg;

    logic                  in_valid_reg, in_valid_next;
    op_t                   in_op_reg;
    logic                  in_restart_reg;
    logic [BLOCK_W-1:0]    in_data_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [BLOCK_W-1:0]    out_data_reg;

    logic                  out_free;
    logic                  advance;
    logic [ROUNDS:0][BLOCK_W-1:0] round_keys;
    res_t                  res;

    assign cfg_ready = 1'b1;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = out_free ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            iv_reg       <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_KEY_LOW:     key_low_reg  <= cfg_data;
                CFG_KEY_HIGH:    key_high_reg <= cfg_data[KEY_HIGH_W-1:0];
                CFG_INIT_VECTOR: iv_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chain_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance && res.chain_we) begin
                chain_reg <= res.chain_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg      <= op_t'(s_tuser[1:0]);
            in_restart_reg <= s_tuser[2];
            in_data_reg    <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= res.data_out;
        end
    end

    spbc_key_sched #(
        .ROUNDS(ROUNDS)
    ) u_key_sched (
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .round_keys (round_keys)
    );

    spbc_cipher #(
        .ROUNDS(ROUNDS)
    ) u_cipher (
        .op          (in_op_reg),
        .restart     (in_restart_reg),
        .data_in     (in_data_reg),
        .init_vector (iv_reg),
        .chain_value (chain_reg),
        .round_keys  (round_keys),
        .res         (res)
    );

endmodule

FILE: rtl/spbc_checker.sv
module spbc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [spbc_pkg::BLOCK_W-1:0] m_tdata
);

    // result word held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed or dropped while stalled");

    // input side only stalls when the result register is full
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with result register empty");

    // input stalls only when the result side is blocked as well
    a_ready_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> !m_tready)
        else $error("input stalled while result side was taking words");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind spn_block_cipher_64 spbc_checker u_spbc_checker (.*);
